>>> design/lge_pkg.sv
`timescale 1ns / 1ps

package lge_pkg;

    // Default grid bounds, handed to the top level parameters.
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    // Fixed field widths of the channels.
    localparam int CMD_W       = 2;
    localparam int ROW_W       = 8;
    localparam int COL_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_IN_USE = CFG_INDEX_W'(1);
    localparam logic [CFG_DATA_W-1:0]  ROWS_RESET      = CFG_DATA_W'(256);
    localparam logic [CFG_DATA_W-1:0]  COLS_RESET      = CFG_DATA_W'(256);

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Position flags that travel with each scan position into the window pipeline.
    typedef struct packed {
        logic valid;
        logic first_col;
        logic col_pad;
        logic row_pad;
        logic row_ge1;
        logic row_ge2;
        logic center_ok;
    } scan_tag_t;

    // New value of one center cell coming out of the window pipeline.
    typedef struct packed {
        logic en;
        logic value;
    } cell_upd_t;

endpackage

>>> design/lge_if.sv
`timescale 1ns / 1ps

// Command channel: one transfer carries one command item.
interface lge_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [lge_pkg::CMD_W-1:0]    command;
    logic [lge_pkg::ROW_W-1:0]    row;
    logic [lge_pkg::COL_W-1:0]    column;
    logic                         write_value;

    modport source (output valid, output command, output row, output column,
                    output write_value, input ready);
    modport sink   (input valid, input command, input row, input column,
                    input write_value, output ready);
endinterface

// Result channel: one transfer carries one result item.
interface lge_res_if;
    logic                         valid;
    logic                         ready;
    logic                         cell_value;
    logic [lge_pkg::CMD_W-1:0]    done_command;

    modport source (output valid, output cell_value, output done_command, input ready);
    modport sink   (input valid, input cell_value, input done_command, output ready);
endinterface

// Configuration write channel.
interface lge_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lge_pkg::CFG_INDEX_W-1:0]   index;
    logic [lge_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/lge_ram.sv
`timescale 1ns / 1ps

module lge_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/lge_window.sv
`timescale 1ns / 1ps

module lge_window #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  lge_pkg::scan_tag_t                                    tag,
    input  logic [$clog2(MAX_COLS)-1:0]                           lb_idx,
    input  logic [$clog2(MAX_ROWS*MAX_COLS+MAX_COLS+1)-1:0]       lin,
    input  logic                                                  grid_bit,
    output lge_pkg::cell_upd_t                                    upd,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]                  upd_addr,
    output logic                                                  busy
);

    localparam int LB_AW  = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(MAX_ROWS*MAX_COLS);
    localparam int LIN_W  = $clog2(MAX_ROWS*MAX_COLS+MAX_COLS+1);
    localparam logic [LIN_W-1:0] CENTER_OFS = LIN_W'(MAX_COLS + 1);

    // B3/S23: three neighbors give birth, two keep the cell, anything else kills it.
    function automatic logic life_rule(input logic [3:0] count, input logic self_bit);
        logic result;
        begin
            result = 1'b0;
            if (count == 4'd3)
            begin
                result = 1'b1;
            end
            else if (count == 4'd2)
            begin
                result = self_bit;
            end
            return result;
        end
    endfunction

    lge_pkg::scan_tag_t s1_tag_reg;
    lge_pkg::scan_tag_t s2_tag_reg;
    logic [LB_AW-1:0]   s1_lb_idx_reg;
    logic [LIN_W-1:0]   s1_lin_reg;
    logic [LIN_W-1:0]   s2_lin_reg;
    logic [2:0]         win0_reg;
    logic [2:0]         win1_reg;
    logic [2:0]         win2_reg;

    logic [1:0]         lb_rdata;
    logic [1:0]         lb_wdata;
    logic               lb_we;
    logic               col_live;
    logic               bot_bit;
    logic               mid_bit;
    logic               top_bit;
    logic [3:0]         neighbors;

    // Line buffer: bit 0 holds the previous row, bit 1 the row before it.
    lge_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .clk   (clk),
        .we    (lb_we),
        .waddr (s1_lb_idx_reg),
        .wdata (lb_wdata),
        .raddr (lb_idx),
        .rdata (lb_rdata)
    );

    // Stage 1: assemble the column of three cells, masking the border.
    always_comb
    begin
        col_live = !s1_tag_reg.col_pad;
        bot_bit  = grid_bit    & !s1_tag_reg.row_pad & col_live;
        mid_bit  = lb_rdata[0] & s1_tag_reg.row_ge1  & col_live;
        top_bit  = lb_rdata[1] & s1_tag_reg.row_ge2  & col_live;
        lb_we    = s1_tag_reg.valid && col_live;
        lb_wdata = {mid_bit, bot_bit};
    end

    // Pipeline flags and addresses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lb_idx_reg <= lb_idx;
        s1_lin_reg    <= lin;
        s2_lin_reg    <= s1_lin_reg;
    end

    // Stage 2: three-column window, cleared at the start of each row.
    always_ff @(posedge clk)
    begin
        if (s1_tag_reg.valid)
        begin
            win0_reg <= {top_bit, mid_bit, bot_bit};
            win1_reg <= s1_tag_reg.first_col ? 3'b000 : win0_reg;
            win2_reg <= s1_tag_reg.first_col ? 3'b000 : win1_reg;
        end
    end

    // Stage 3: count neighbors of the center cell and apply the rule.
    always_comb
    begin
        neighbors = 4'(win0_reg[0]) + 4'(win0_reg[1]) + 4'(win0_reg[2])
                  + 4'(win1_reg[0]) + 4'(win1_reg[2])
                  + 4'(win2_reg[0]) + 4'(win2_reg[1]) + 4'(win2_reg[2]);
        upd.en    = s2_tag_reg.valid && s2_tag_reg.center_ok;
        upd.value = life_rule(neighbors, win1_reg[1]);
        upd_addr  = ADDR_W'(s2_lin_reg - CENTER_OFS);
        busy      = s1_tag_reg.valid || s2_tag_reg.valid;
    end

endmodule

>>> design/lge_ctrl.sv
`timescale 1ns / 1ps

module lge_ctrl #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    lge_cmd_if.sink                                            cmd,
    lge_res_if.source                                          res,
    lge_cfg_if.sink                                            cfg,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]               grid_raddr,
    input  logic                                               grid_rdata,
    output logic                                               grid_we,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]               grid_waddr,
    output logic                                               grid_wdata,
    output lge_pkg::scan_tag_t                                 scan_tag,
    output logic [$clog2(MAX_COLS)-1:0]                        lb_idx,
    output logic [$clog2(MAX_ROWS*MAX_COLS+MAX_COLS+1)-1:0]    lin,
    input  lge_pkg::cell_upd_t                                 upd,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]               upd_addr,
    input  logic                                               sweep_busy
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = $clog2(DEPTH + MAX_COLS + 1);
    localparam int LB_AW  = $clog2(MAX_COLS);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int CC_W   = $clog2(MAX_COLS + 1);
    localparam int ER_W   = (RC_W > lge_pkg::CFG_DATA_W) ? RC_W : lge_pkg::CFG_DATA_W;
    localparam int EC_W   = (CC_W > lge_pkg::CFG_DATA_W) ? CC_W : lge_pkg::CFG_DATA_W;
    localparam logic [LIN_W-1:0] LAST_ADDR  = LIN_W'(DEPTH - 1);
    localparam logic [LIN_W-1:0] ROW_STRIDE = LIN_W'(MAX_COLS);

    lge_pkg::state_t                  state_reg;
    lge_pkg::state_t                  state_next;
    logic [lge_pkg::CFG_DATA_W-1:0]   rows_reg;
    logic [lge_pkg::CFG_DATA_W-1:0]   cols_reg;
    logic [LIN_W-1:0]                 lin_reg;
    logic [LIN_W-1:0]                 rowbase_reg;
    logic [RC_W-1:0]                  ir_reg;
    logic [CC_W-1:0]                  ic_reg;
    logic                             inside_reg;
    logic [lge_pkg::CMD_W-1:0]        pend_cmd_reg;
    logic                             pend_value_reg;
    logic                             out_valid_reg;
    logic                             cell_value_reg;
    logic [lge_pkg::CMD_W-1:0]        done_cmd_reg;

    logic [RC_W-1:0]                  eff_rows;
    logic [CC_W-1:0]                  eff_cols;
    logic                             area_empty;
    logic                             in_area;
    logic [ADDR_W-1:0]                cmd_addr;
    logic                             accept;
    lge_pkg::cmd_t                    cmd_code;
    logic                             col_end;
    logic                             row_end;
    logic                             out_load;

    // Active area, with register values above the maximum saturated.
    always_comb
    begin
        eff_rows = (ER_W'(rows_reg) > ER_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : RC_W'(rows_reg);
        eff_cols = (EC_W'(cols_reg) > EC_W'(MAX_COLS)) ? CC_W'(MAX_COLS) : CC_W'(cols_reg);
        area_empty = (eff_rows == '0) || (eff_cols == '0);
        in_area  = (ER_W'(cmd.row) < ER_W'(eff_rows)) && (EC_W'(cmd.column) < EC_W'(eff_cols));
        cmd_addr = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_COLS) + ADDR_W'(cmd.column));
        accept   = cmd.valid && cmd.ready;
        cmd_code = lge_pkg::cmd_t'(cmd.command);
        col_end  = (ic_reg == eff_cols);
        row_end  = (ir_reg == eff_rows);
        out_load = (state_reg == lge_pkg::ST_DONE) && (!out_valid_reg || res.ready);
    end

    // Configuration registers; writes are taken in every cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= lge_pkg::ROWS_RESET;
            cols_reg <= lge_pkg::COLS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                lge_pkg::CFG_ROWS_IN_USE: rows_reg <= cfg.data;
                lge_pkg::CFG_COLS_IN_USE: cols_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lge_pkg::ST_INIT:
            begin
                if (lin_reg == LAST_ADDR)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_code)
                        lge_pkg::CMD_WRITE: state_next = lge_pkg::ST_DONE;
                        lge_pkg::CMD_READ:  state_next = lge_pkg::ST_READ;
                        lge_pkg::CMD_STEP:  state_next = area_empty ? lge_pkg::ST_DONE
                                                                    : lge_pkg::ST_SCAN;
                        lge_pkg::CMD_CLEAR: state_next = lge_pkg::ST_CLEAR;
                        default:            state_next = lge_pkg::ST_DONE;
                    endcase
                end
            end
            lge_pkg::ST_READ:
            begin
                state_next = lge_pkg::ST_DONE;
            end
            lge_pkg::ST_CLEAR:
            begin
                if (lin_reg == LAST_ADDR)
                begin
                    state_next = lge_pkg::ST_DONE;
                end
            end
            lge_pkg::ST_SCAN:
            begin
                if (col_end && row_end)
                begin
                    state_next = lge_pkg::ST_DRAIN;
                end
            end
            lge_pkg::ST_DRAIN:
            begin
                if (!sweep_busy)
                begin
                    state_next = lge_pkg::ST_DONE;
                end
            end
            lge_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            default: state_next = lge_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lge_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs: handshake, grid port selection and scan position flags.
    always_comb
    begin
        cmd.ready  = (state_reg == lge_pkg::ST_IDLE);
        grid_we    = 1'b0;
        grid_waddr = '0;
        grid_wdata = 1'b0;
        grid_raddr = '0;
        case (state_reg)
            lge_pkg::ST_INIT, lge_pkg::ST_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = ADDR_W'(lin_reg);
            end
            lge_pkg::ST_IDLE:
            begin
                grid_we    = accept && (cmd_code == lge_pkg::CMD_WRITE) && in_area;
                grid_waddr = cmd_addr;
                grid_wdata = cmd.write_value;
                grid_raddr = cmd_addr;
            end
            lge_pkg::ST_SCAN, lge_pkg::ST_DRAIN:
            begin
                grid_we    = upd.en;
                grid_waddr = upd_addr;
                grid_wdata = upd.value;
                grid_raddr = (col_end || row_end) ? '0 : ADDR_W'(lin_reg);
            end
            default: ;
        endcase

        scan_tag.valid     = (state_reg == lge_pkg::ST_SCAN);
        scan_tag.first_col = (ic_reg == '0);
        scan_tag.col_pad   = col_end;
        scan_tag.row_pad   = row_end;
        scan_tag.row_ge1   = (ir_reg != '0);
        scan_tag.row_ge2   = (ir_reg > RC_W'(1));
        scan_tag.center_ok = (ir_reg != '0) && (ic_reg != '0);
        lb_idx             = col_end ? '0 : LB_AW'(ic_reg);
        lin                = lin_reg;
    end

    // Sweep counters and the pending result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg        <= '0;
            rowbase_reg    <= '0;
            ir_reg         <= '0;
            ic_reg         <= '0;
            inside_reg     <= 1'b0;
            pend_cmd_reg   <= '0;
            pend_value_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                lge_pkg::ST_INIT, lge_pkg::ST_CLEAR:
                begin
                    lin_reg <= lin_reg + LIN_W'(1);
                end
                lge_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        lin_reg        <= '0;
                        rowbase_reg    <= '0;
                        ir_reg         <= '0;
                        ic_reg         <= '0;
                        inside_reg     <= in_area;
                        pend_cmd_reg   <= cmd.command;
                        pend_value_reg <= 1'b0;
                    end
                end
                lge_pkg::ST_READ:
                begin
                    pend_value_reg <= inside_reg & grid_rdata;
                end
                lge_pkg::ST_SCAN:
                begin
                    if (col_end)
                    begin
                        ic_reg      <= '0;
                        ir_reg      <= ir_reg + RC_W'(1);
                        rowbase_reg <= rowbase_reg + ROW_STRIDE;
                        lin_reg     <= rowbase_reg + ROW_STRIDE;
                    end
                    else
                    begin
                        ic_reg  <= ic_reg + CC_W'(1);
                        lin_reg <= lin_reg + LIN_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: the next command is taken while a result waits here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cell_value_reg <= pend_value_reg;
            done_cmd_reg   <= pend_cmd_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.cell_value   = cell_value_reg;
    assign res.done_command = done_cmd_reg;

    // The window pipeline writes the grid only while a generation is running.
    a_sweep_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> (state_reg == lge_pkg::ST_SCAN || state_reg == lge_pkg::ST_DRAIN))
        else $error("window update outside a generation step");

    // The window pipeline is empty whenever no generation is running.
    a_pipe_empty_outside_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lge_pkg::ST_SCAN && state_reg != lge_pkg::ST_DRAIN) |-> !sweep_busy)
        else $error("window pipeline busy outside a generation step");

    // Only a read result can carry a live cell.
    a_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cell_value_reg) |-> (done_cmd_reg == lge_pkg::CMD_READ))
        else $error("nonzero cell value on a result that is not a read");

endmodule

>>> design/life_generation_engine_core.sv
`timescale 1ns / 1ps

// Conway life engine (B3/S23) on a bounded grid of MAX_ROWS x MAX_COLS one-bit cells held
// in a single-port-write, single-port-read memory. Only the top-left area set by
// rows_in_use and cols_in_use takes part; cells outside it read as 0, ignore writes and
// count as dead neighbors. A write goes through the done state and a read through the read
// and done states before its result is loaded. A generation step sweeps the active area
// once at one cell per cycle through a two-row line buffer and a three-column window.
// A clear writes every cell of the grid, one per cycle. After reset the block runs the same
// clearing pass before it takes the first command; configuration writes are taken at any
// time. Results wait in an output register, so a new command is taken while the previous
// result is still unread.
module life_generation_engine_core #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic       clk,
    input  logic       rst_n,
    lge_cmd_if.sink    cmd,
    lge_res_if.source  res,
    lge_cfg_if.sink    cfg
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = $clog2(DEPTH + MAX_COLS + 1);
    localparam int LB_AW  = $clog2(MAX_COLS);

    logic [ADDR_W-1:0]  grid_raddr;
    logic               grid_rdata;
    logic               grid_we;
    logic [ADDR_W-1:0]  grid_waddr;
    logic               grid_wdata;
    lge_pkg::scan_tag_t scan_tag;
    logic [LB_AW-1:0]   lb_idx;
    logic [LIN_W-1:0]   lin;
    lge_pkg::cell_upd_t upd;
    logic [ADDR_W-1:0]  upd_addr;
    logic               sweep_busy;

    // Grid storage.
    lge_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // Command sequencing, sweep counters and result register.
    lge_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .cfg        (cfg),
        .grid_raddr (grid_raddr),
        .grid_rdata (grid_rdata),
        .grid_we    (grid_we),
        .grid_waddr (grid_waddr),
        .grid_wdata (grid_wdata),
        .scan_tag   (scan_tag),
        .lb_idx     (lb_idx),
        .lin        (lin),
        .upd        (upd),
        .upd_addr   (upd_addr),
        .sweep_busy (sweep_busy)
    );

    // Neighborhood window and rule evaluation.
    lge_window #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag      (scan_tag),
        .lb_idx   (lb_idx),
        .lin      (lin),
        .grid_bit (grid_rdata),
        .upd      (upd),
        .upd_addr (upd_addr),
        .busy     (sweep_busy)
    );

endmodule

>>> test/lge_life_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and configuration channels of the life engine, keeps its own
// copy of the grid and the active area, and compares every result with the oldest expected one.
module lge_life_checker #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic clk,
    input  logic rst_n,
    lge_cmd_if   cmd,
    lge_res_if   res,
    lge_cfg_if   cfg,
    output int   mismatches,
    output int   results_outstanding
);
    import lge_pkg::*;

    typedef struct packed {
        logic cell_value;
        cmd_t done_command;
    } life_result_t;

    // Expected results in command order, and the predicted grid and area registers.
    life_result_t                 expected_results[$];
    bit [MAX_COLS-1:0]            cells [MAX_ROWS];
    logic [CFG_DATA_W-1:0]        rows_cfg;
    logic [CFG_DATA_W-1:0]        cols_cfg;
    life_result_t                 want;

    // Register values above the grid bounds saturate to the bounds.
    function automatic int active_rows();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    endfunction

    function automatic int active_cols();
        return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic void clear_cells();
        foreach (cells[i])
        begin
            cells[i] = '0;
        end
    endfunction

    // One B3/S23 generation over the active area; everything outside it is dead and untouched.
    function automatic void advance_generation();
        bit [MAX_COLS-1:0] next_cells [MAX_ROWS];
        int                nr;
        int                nc;
        int                live;
        nr = active_rows();
        nc = active_cols();
        next_cells = cells;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
                            c + dc >= 0 && c + dc < nc)
                        begin
                            live += int'(cells[r + dr][c + dc]);
                        end
                    end
                end
                next_cells[r][c] = (live == 3) || (live == 2 && cells[r][c]);
            end
        end
        cells = next_cells;
    endfunction

    // Applies one command to the predicted grid and returns the result it must produce.
    function automatic life_result_t apply_command(input cmd_t op, input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c, input logic wv);
        life_result_t outcome;
        logic         hit;
        hit = (int'(r) < active_rows()) && (int'(c) < active_cols());
        outcome.cell_value   = 1'b0;
        outcome.done_command = op;
        case (op)
            CMD_WRITE:
            begin
                if (hit)
                    cells[r][c] = wv;
            end
            CMD_READ:
            begin
                if (hit)
                    outcome.cell_value = cells[r][c];
            end
            CMD_STEP:
                advance_generation();
            default:
                clear_cells();
        endcase
        return outcome;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: life engine mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Result transfers are checked before the command of the same edge is predicted, since a
    // result can never belong to a command accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            clear_cells();
            rows_cfg            = ROWS_RESET;
            cols_cfg            = COLS_RESET;
            mismatches          = 0;
            results_outstanding = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, done_command %0d",
                                              res.done_command));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.cell_value !== want.cell_value)
                        report_mismatch($sformatf("cell_value %b, expected %b for %s",
                                                  res.cell_value, want.cell_value,
                                                  want.done_command.name()));
                    if (res.done_command !== want.done_command)
                        report_mismatch($sformatf("done_command %0d, expected %s",
                                                  res.done_command,
                                                  want.done_command.name()));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ROWS_IN_USE)
                    rows_cfg = cfg.data;
                else if (cfg.index == CFG_COLS_IN_USE)
                    cols_cfg = cfg.data;
            end
            if (cmd.valid && cmd.ready)
            begin
                expected_results.push_back(apply_command(cmd_t'(cmd.command), cmd.row,
                                                         cmd.column, cmd.write_value));
            end
            results_outstanding = expected_results.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lge_pkg::*;

    localparam int WATCHDOG_LIMIT  = 300000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 13;
    localparam int SEED_WRITES     = 6;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   results_pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off_request;
    int   quiet_cycles;
    int   grid_rows;
    int   grid_cols;
    int   clears_left;

    lge_cmd_if cmd_if ();
    lge_res_if res_if ();
    lge_cfg_if cfg_if ();

    life_generation_engine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    lge_life_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd_if),
        .res                 (res_if),
        .cfg                 (cfg_if),
        .mismatches          (fail_count),
        .results_outstanding (results_pending)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: ends the run when no channel has seen a transfer for too long.
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off when the stimulus asks for it.
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_request = 1'b0;
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one command, after a random number of idle cycles, and waits for its transfer.
    task automatic send_command(input cmd_t op, input logic [ROW_W-1:0] r,
                                input logic [COL_W-1:0] c, input logic wv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= op;
        cmd_if.row         <= r;
        cmd_if.column      <= c;
        cmd_if.write_value <= wv;
        do
            @(posedge clk);
        while (!cmd_if.ready);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stops offering commands and waits until every expected result has come back.
    task automatic wait_until_drained();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // Sets the active area once the block is idle; the stimulus aims at the saturated size.
    task automatic configure_area(input logic [CFG_DATA_W-1:0] rows,
                                  input logic [CFG_DATA_W-1:0] cols);
        wait_until_drained();
        write_register(CFG_ROWS_IN_USE, rows);
        write_register(CFG_COLS_IN_USE, cols);
        grid_rows = (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows);
        grid_cols = (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols);
    endtask

    // Stimulus: reset, a directed part, then random phases with different areas and idling.
    initial
    begin
        cmd_t             op;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        int               roll;

        rst_n              = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_WRITE;
        cmd_if.row         = '0;
        cmd_if.column      = '0;
        cmd_if.write_value = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_ROWS_IN_USE;
        cfg_if.data        = '0;
        hold_off_request   = 1'b0;
        quiet_cycles       = 0;
        send_idle_pct      = 32;
        recv_stall_pct     = 69;
        clears_left        = 1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Full grid, with a row count above the bound: a still block in one corner and a lone
        // cell in the opposite corner, which dies at the step.
        configure_area(9'd511, 9'd256);
        send_command(CMD_WRITE, 8'd255, 8'd255, 1'b1);
        send_command(CMD_READ, 8'd255, 8'd255, 1'b0);
        send_command(CMD_WRITE, 8'd0, 8'd0, 1'b1);
        send_command(CMD_WRITE, 8'd0, 8'd1, 1'b1);
        send_command(CMD_WRITE, 8'd1, 8'd0, 1'b1);
        send_command(CMD_WRITE, 8'd1, 8'd1, 1'b1);
        send_command(CMD_WRITE, 8'd2, 8'd2, 1'b0);
        send_command(CMD_STEP, 8'hAA, 8'h55, 1'b1);
        send_command(CMD_READ, 8'd0, 8'd0, 1'b1);
        send_command(CMD_READ, 8'd255, 8'd255, 1'b0);

        // Empty area: reads give 0, writes are dropped, a step changes nothing.
        configure_area(9'd0, 9'd5);
        send_command(CMD_WRITE, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ, 8'd0, 8'd0, 1'b0);
        send_command(CMD_STEP, 8'h55, 8'hAA, 1'b0);

        // Single cell area, plus writes to indexes with no register behind them.
        configure_area(9'd1, 9'd1);
        write_register(CFG_SPARE_A, 9'h1FF);
        write_register(CFG_SPARE_B, 9'h000);
        send_command(CMD_READ, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ, 8'd0, 8'd1, 1'b0);
        send_command(CMD_WRITE, 8'd0, 8'd1, 1'b0);
        send_command(CMD_STEP, 8'd0, 8'd0, 1'b0);

        // Cells kept outside the area come back when it grows; clear wipes the whole grid.
        configure_area(9'd2, 9'd511);
        send_command(CMD_READ, 8'd0, 8'd1, 1'b0);
        send_command(CMD_READ, 8'd0, 8'd0, 1'b0);
        send_command(CMD_CLEAR, 8'hFF, 8'h00, 1'b1);
        send_command(CMD_READ, 8'd0, 8'd1, 1'b0);
        send_command(CMD_READ, 8'd1, 8'd1, 1'b0);

        // Random phases: each starts by seeding live cells, then mixes all commands.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct  = 32;
                recv_stall_pct = 69;
            end
            else if (p < 4)
            begin
                send_idle_pct  = 69;
                recv_stall_pct = 32;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (p == 2)
                configure_area(9'd256, 9'd2);
            else
                configure_area(CFG_DATA_W'($urandom_range(1, 12)),
                               CFG_DATA_W'($urandom_range(1, 12)));
            if (p == 4)
                hold_off_request = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                roll = $urandom_range(99);
                if (k < SEED_WRITES || roll < 45)
                    op = CMD_WRITE;
                else if (roll < 78)
                    op = CMD_READ;
                else if (roll < 97 || clears_left == 0)
                    op = CMD_STEP;
                else
                begin
                    op = CMD_CLEAR;
                    clears_left--;
                end
                // Mostly cells inside the area, sometimes anywhere on the grid.
                if ($urandom_range(99) < 85)
                begin
                    r = ROW_W'($urandom_range(grid_rows - 1));
                    c = COL_W'($urandom_range(grid_cols - 1));
                end
                else
                begin
                    r = ROW_W'($urandom_range(255));
                    c = COL_W'($urandom_range(255));
                end
                send_command(op, r, c, $urandom_range(99) < 65);
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
design/lge_pkg.sv
design/lge_if.sv
design/lge_ram.sv
design/lge_window.sv
design/lge_ctrl.sv
design/life_generation_engine_core.sv
test/lge_life_checker.sv
test/tb_top.sv
